// ===== rtl/rpps_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, widths and controller/datapath command types for the
// prime prefix pair selector. No dependencies.
package rpps_pkg;

  localparam int unsigned PREFIX_BITS = 13;
  localparam int unsigned A_W   = PREFIX_BITS;      // prefix width
  localparam int unsigned B_W   = PREFIX_BITS + 1;  // partner width, holds HI itself
  localparam int unsigned SEP_W = 12;
  localparam int unsigned RV_W  = 25;
  localparam int unsigned CNT_W = 25;
  localparam int unsigned IDX_W = RV_W - 1;

  localparam logic [A_W-1:0] PFX_LO  = A_W'(1) << (PREFIX_BITS - 1);
  localparam logic [A_W-1:0] PFX_MAX = {A_W{1'b1}};
  localparam logic [B_W-1:0] PFX_HI  = B_W'(1) << PREFIX_BITS;
  // ceil(2*LO*LO / LO) at the first prefix
  localparam logic [B_W-1:0] Q_INIT  = PFX_HI;

  localparam logic [SEP_W-1:0] SEP_RESET = SEP_W'(2);

  // upper bound on quotient decrements per prefix step
  localparam int unsigned Q_DEC_STEPS = 3;

  typedef struct packed {
    logic start;     // load a new transaction, restart the sweep
    logic step;      // evaluate the current prefix and advance
    logic load_out;  // move the result into the output register
  } rpps_cmd_t;

  typedef struct packed {
    logic last_a;    // current prefix is the final one
  } rpps_sts_t;

endpackage

// ===== rtl/rpps_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the prime prefix pair selector.
// Depends on rpps_pkg for the field widths.
interface rpps_in_if import rpps_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RV_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

interface rpps_out_if import rpps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [A_W-1:0]   first_prefix;
  logic [A_W-1:0]   second_prefix;
  logic [CNT_W-1:0] pair_count;
  logic             out_of_range;

  modport source (output valid, output first_prefix, output second_prefix,
                  output pair_count, output out_of_range, input ready);
  modport sink   (input valid, input first_prefix, input second_prefix,
                  input pair_count, input out_of_range, output ready);
endinterface

// ===== rtl/rpps_dp.sv =====
`timescale 1ns / 1ps
// Datapath: separation register, incremental ceiling quotient per prefix,
// running pair count, selection and output register. Depends on rpps_pkg.
module rpps_dp import rpps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SEP_W-1:0] cfg_wdata_i,
  input  logic [RV_W-1:0]  rv_i,
  input  rpps_cmd_t        cmd_i,
  output rpps_sts_t        sts_o,
  output logic [A_W-1:0]   first_o,
  output logic [A_W-1:0]   second_o,
  output logic [CNT_W-1:0] count_o,
  output logic             oor_o
);

  logic [SEP_W-1:0] sep_q;
  logic [RV_W-1:0]  rv_q;
  logic [A_W-1:0]   a_q;
  logic [B_W-1:0]   q_q, r_q;       // q = ceil(2*LO*LO / a), r = q*a - 2*LO*LO
  logic             s1_valid_q;
  logic [A_W-1:0]   a_s1_q;
  logic [B_W-1:0]   bmin_s1_q;
  logic [CNT_W-1:0] cum_q;
  logic             found_q;
  logic [A_W-1:0]   first_q, sec_q;
  logic [A_W-1:0]   first_out_q, sec_out_q;
  logic [CNT_W-1:0] cnt_out_q;
  logic             oor_out_q;

  logic [B_W-1:0]   a_nxt, r_acc, q_acc, lim, bmin;
  logic [CNT_W-1:0] span, cum_nxt, idx, offs;
  logic             hit;
  logic [A_W-1:0]   sec_hit;

  // stage 1: least partner for a_q, quotient/residue update for a_q + 1
  always_comb begin
    a_nxt = {1'b0, a_q} + B_W'(1);
    r_acc = r_q + q_q;
    q_acc = q_q;
    for (int i = 0; i < Q_DEC_STEPS; i++) begin
      if (r_acc >= a_nxt) begin
        r_acc = r_acc - a_nxt;
        q_acc = q_acc - B_W'(1);
      end
    end
    lim  = {1'b0, a_q} + B_W'(sep_q);
    bmin = (q_q > lim) ? q_q : lim;
    if (bmin > PFX_HI) begin
      bmin = PFX_HI;
    end
  end

  // stage 2: accumulate the count and pick the indexed pair
  always_comb begin
    span    = CNT_W'(PFX_HI - bmin_s1_q);
    cum_nxt = cum_q + span;
    idx     = CNT_W'(rv_q[RV_W-1:1]);
    hit     = !found_q && (idx < cum_nxt);
    offs    = idx - cum_q;
    sec_hit = A_W'(bmin_s1_q + offs[B_W-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q      <= SEP_RESET;
      s1_valid_q <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sep_q <= cfg_wdata_i;
      end
      s1_valid_q <= cmd_i.step;
      if (cmd_i.start) begin
        found_q <= 1'b0;
      end else if (s1_valid_q && hit) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rv_q    <= rv_i;
      a_q     <= PFX_LO;
      q_q     <= Q_INIT;
      r_q     <= '0;
      cum_q   <= '0;
      first_q <= '0;
      sec_q   <= '0;
    end else begin
      if (cmd_i.step) begin
        a_q       <= a_nxt[A_W-1:0];
        q_q       <= q_acc;
        r_q       <= r_acc;
        a_s1_q    <= a_q;
        bmin_s1_q <= bmin;
      end
      if (s1_valid_q) begin
        cum_q <= cum_nxt;
        if (hit) begin
          first_q <= a_s1_q;
          sec_q   <= sec_hit;
        end
      end
    end
    if (cmd_i.load_out) begin
      first_out_q <= (found_q && rv_q[0]) ? sec_q : first_q;
      sec_out_q   <= (found_q && rv_q[0]) ? first_q : sec_q;
      cnt_out_q   <= cum_q;
      oor_out_q   <= ({1'b0, rv_q} >= {cum_q, 1'b0});
    end
  end

  assign sts_o.last_a = (a_q == PFX_MAX);
  assign first_o      = first_out_q;
  assign second_o     = sec_out_q;
  assign count_o      = cnt_out_q;
  assign oor_o        = oor_out_q;

  a_bmin_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (bmin_s1_q <= PFX_HI))
    else $error("least partner above cap");

  a_pair_sep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && hit |-> ({1'b0, sec_hit} >= ({1'b0, a_s1_q} + B_W'(sep_q))))
    else $error("selected pair violates separation");

  // zero separation allows a prefix to pair with itself
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && hit |-> (sec_hit >= a_s1_q))
    else $error("selected partner below prefix");

endmodule

// ===== rtl/rpps_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences accept, prefix sweep, pipeline flush and result
// handoff. Depends on rpps_pkg for the command and status types.
module rpps_ctrl import rpps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  rpps_sts_t sts_i,
  output rpps_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.start    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.step     = (state_q == ST_RUN);
    cmd_o.load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) begin
        state_d = ST_RUN;
      end
      ST_RUN:   if (sts_i.last_a) begin
        state_d = ST_FLUSH;
      end
      ST_FLUSH: state_d = ST_DONE;
      ST_DONE:  if (cmd_o.load_out) begin
        state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == ST_RUN))
    else $error("accepted transaction did not start sweep");

  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) && sts_i.last_a |=> (state_q == ST_FLUSH))
    else $error("sweep did not end at last prefix");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("result load did not raise valid");

endmodule

// ===== rtl/rsa_prime_prefix_pair_select.sv =====
`timescale 1ns / 1ps
// Top level of the prime prefix pair selector: controller plus datapath.
// Depends on rpps_pkg, rpps_if, rpps_ctrl and rpps_dp.

// One transaction is processed at a time. After a random value is accepted
// the block sweeps all 4096 prefixes once, one prefix per cycle, tracking
// ceil(2^25/a) incrementally and accumulating the pair count and the
// selected pair in the same pass. After the sweep the controller flushes the
// pipeline, loads the output register and returns to idle before the next
// random value is taken. A new random value can be accepted while the
// previous result still waits on the output. The pair separation register
// is written through cfg_we_i/cfg_wdata_i and resets to 2. The user is to
// write it only while the block is idle; the block itself does not enforce
// this.
module rsa_prime_prefix_pair_select import rpps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SEP_W-1:0] cfg_wdata_i,
  rpps_in_if.sink          in_i,
  rpps_out_if.source       out_o
);

  rpps_cmd_t cmd;
  rpps_sts_t sts;

  rpps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rpps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rv_i        (in_i.random_value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .first_o     (out_o.first_prefix),
    .second_o    (out_o.second_prefix),
    .count_o     (out_o.pair_count),
    .oor_o       (out_o.out_of_range)
  );

endmodule

// ===== bench/rsa_prime_prefix_pair_select_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for rsa_prime_prefix_pair_select: drives random values,
// predicts each prefix pair and compares it with the block's result.
// Depends on rpps_pkg, rpps_if and the RTL top level.
module rsa_prime_prefix_pair_select_tb;
  import rpps_pkg::*;

  localparam longint unsigned LO_L = 64'd1 << (PREFIX_BITS - 1);
  localparam longint unsigned HI_L = 64'd1 << PREFIX_BITS;
  localparam logic [RV_W-1:0] RV_ALL = {RV_W{1'b1}};
  localparam int unsigned HOLD_CYCLES = 15000;
  localparam int unsigned RAND_PER_PHASE = 15;

  typedef struct packed {
    logic [A_W-1:0]   first_prefix;
    logic [A_W-1:0]   second_prefix;
    logic [CNT_W-1:0] pair_count;
    logic             out_of_range;
  } prefix_pair_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [SEP_W-1:0] cfg_wdata_i;

  rpps_in_if  in_if ();
  rpps_out_if out_if ();

  rsa_prime_prefix_pair_select u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  prefix_pair_t     pending_pairs[$];
  logic [SEP_W-1:0] cur_sep = SEP_RESET;
  longint unsigned  cur_total;
  int unsigned      n_sent;
  int unsigned      n_checked;
  int unsigned      n_mismatch;
  int unsigned      n_settings;
  int unsigned      hold_cycles;
  bit               idle_off;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // least partner b for smaller prefix a: ceil(2*LO*LO/a), at least a+sep, at most HI
  function automatic longint unsigned least_partner(longint unsigned a, longint unsigned sep);
    longint unsigned b;
    b = (2 * LO_L * LO_L + a - 1) / a;
    if (b < a + sep) b = a + sep;
    if (b > HI_L) b = HI_L;
    return b;
  endfunction

  function automatic longint unsigned count_pairs(longint unsigned sep);
    longint unsigned total;
    total = 0;
    for (longint unsigned a = LO_L; a < HI_L; a++) total += HI_L - least_partner(a, sep);
    return total;
  endfunction

  function automatic prefix_pair_t pick_prefix_pair(logic [RV_W-1:0] rv,
                                                    logic [SEP_W-1:0] sep,
                                                    longint unsigned total);
    prefix_pair_t    p;
    longint unsigned idx, span, bmin, lo_pfx, hi_pfx;
    bit              found;
    p = '0;
    found = 1'b0;
    lo_pfx = 0;
    hi_pfx = 0;
    idx = longint'(rv) >> 1;
    for (longint unsigned a = LO_L; a < HI_L && !found; a++) begin
      bmin = least_partner(a, sep);
      span = HI_L - bmin;
      if (idx < span) begin
        lo_pfx = a;
        hi_pfx = bmin + idx;
        found = 1'b1;
      end else begin
        idx -= span;
      end
    end
    if (found) begin
      p.first_prefix  = rv[0] ? A_W'(hi_pfx) : A_W'(lo_pfx);
      p.second_prefix = rv[0] ? A_W'(lo_pfx) : A_W'(hi_pfx);
    end
    p.pair_count   = CNT_W'(total);
    p.out_of_range = (longint'(rv) >= 2 * total);
    return p;
  endfunction

  // mostly in-range indexes, the rest drawn over the whole field
  function automatic logic [RV_W-1:0] draw_value();
    if (cur_total > 0 && $urandom_range(0, 9) < 8)
      return RV_W'($urandom_range(0, int'(2 * cur_total - 1)));
    return RV_W'($urandom());
  endfunction

  // call right after a rising edge
  task automatic send_value(input logic [RV_W-1:0] rv);
    int unsigned gap;
    gap = idle_off ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.random_value <= rv;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_pairs.push_back(pick_prefix_pair(rv, cur_sep, cur_total));
    n_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_separation(input logic [SEP_W-1:0] sep);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sep;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_sep   = sep;
    cur_total = count_pairs(sep);
    n_settings++;
  endtask

  // index boundaries: first pair, last pair, first out-of-range values, all ones
  task automatic send_index_edges();
    send_value('0);
    send_value(RV_W'(1));
    send_value(RV_W'(2 * cur_total - 2));
    send_value(RV_W'(2 * cur_total - 1));
    send_value(RV_W'(2 * cur_total));
    send_value(RV_W'(2 * cur_total + 1));
    send_value(RV_ALL);
  endtask

  task automatic test_reset_separation();
    send_index_edges();
    send_value(25'h1555555);
    send_value(25'h0AAAAAA);
    wait_drained();
  endtask

  task automatic test_zero_separation();
    write_separation('0);
    send_index_edges();
    wait_drained();
  endtask

  // only one pair survives a separation one below the top
  task automatic test_narrow_pair_set();
    write_separation(SEP_W'(4094));
    for (int i = 0; i < 4; i++) send_value(RV_W'(i));
    send_value(RV_ALL);
    wait_drained();
  endtask

  // no pair at all: everything is out of range
  task automatic test_no_valid_pairs();
    write_separation({SEP_W{1'b1}});
    send_value('0);
    send_value(RV_W'(1));
    send_value(RV_ALL);
    wait_drained();
  endtask

  task automatic test_random_settings();
    logic [SEP_W-1:0] sep;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: sep = SEP_W'($urandom_range(0, 15));
        1: sep = SEP_W'($urandom_range(16, 1023));
        2: sep = SEP_W'($urandom_range(1024, 4093));
        3: sep = SEP_RESET;
        default: sep = SEP_W'($urandom());
      endcase
      write_separation(sep);
      idle_off = (ph == 3);
      for (int i = 0; i < RAND_PER_PHASE; i++) send_value(draw_value());
      idle_off = 1'b0;
      wait_drained();
    end
  endtask

  // receiver stalls long enough that the block holds a result, takes one more
  // value and then stops accepting
  task automatic test_output_backpressure();
    hold_cycles = HOLD_CYCLES;
    idle_off = 1'b1;
    for (int i = 0; i < 4; i++) send_value(draw_value());
    idle_off = 1'b0;
    wait_drained();
  endtask

  // result receiver: random stalls, optional long hold-off
  initial begin
    int unsigned gap;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = idle_off ? 0 : $urandom_range(0, 6);
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid && hold_cycles == 0) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    prefix_pair_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_pairs.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("[%0t] result with nothing pending: first %0d second %0d count %0d oor %0b",
                   $realtime, out_if.first_prefix, out_if.second_prefix,
                   out_if.pair_count, out_if.out_of_range);
      end else begin
        want = pending_pairs.pop_front();
        n_checked++;
        if (out_if.first_prefix !== want.first_prefix ||
            out_if.second_prefix !== want.second_prefix ||
            out_if.pair_count !== want.pair_count ||
            out_if.out_of_range !== want.out_of_range) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("[%0t] mismatch: exp %0d/%0d cnt %0d oor %0b, got %0d/%0d cnt %0d oor %0b",
                     $realtime, want.first_prefix, want.second_prefix, want.pair_count,
                     want.out_of_range, out_if.first_prefix, out_if.second_prefix,
                     out_if.pair_count, out_if.out_of_range);
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("Timeout with %0d results outstanding", pending_pairs.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    in_if.valid        <= 1'b0;
    in_if.random_value <= '0;
    cur_total = count_pairs(SEP_RESET);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_separation();
    test_zero_separation();
    test_narrow_pair_set();
    test_no_valid_pairs();
    test_random_settings();
    test_output_backpressure();

    repeat (50) @(posedge clk_i);
    $display("Sent %0d random values under %0d separation writes, %0d results checked",
             n_sent, n_settings, n_checked);
    $display("Included index edges, empty pair set and a %0d-cycle output stall",
             HOLD_CYCLES);
    if (n_mismatch == 0 && pending_pairs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, pending_pairs.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
